>>> rtl/async_hdlc_framer_crc16_unit_defines.svh
// Assertion macros used by the framer back end (hdlc_back).
`ifndef ASYNC_HDLC_FRAMER_CRC16_UNIT_DEFINES_SVH
`define ASYNC_HDLC_FRAMER_CRC16_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HDLC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HDLC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hdlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hdlc_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  // One queued payload byte with the FCS that results if it ends the frame.
  typedef struct packed {
    logic [15:0] fcs;
    logic        last;
    logic [7:0]  data;
  } hdlc_item_t;

  typedef enum logic [1:0] {
    BK_DATA,
    BK_FCS_LO,
    BK_FCS_HI,
    BK_FLAG
  } hdlc_bk_state_t;

  // Reflected CRC-16 update, one byte (8 shift steps).
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hdlc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hdlc_front
  import hdlc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       q_full,
  output logic            q_push,
  output hdlc_item_t      q_item
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] crc_upd;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign crc_upd   = crc_fold(crc_r, in_tdata);

  always_comb begin
    q_item.data = in_tdata;
    q_item.last = in_tlast;
    q_item.fcs  = ~crc_upd;
  end

  // CRC restarts after the last byte of each frame.
  always_comb begin
    crc_nxt = crc_r;
    if (q_push) begin
      crc_nxt = in_tlast ? CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hdlc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hdlc_fifo
  import hdlc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire hdlc_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            empty,
  output hdlc_item_t      head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdlc_item_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hdlc_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "async_hdlc_framer_crc16_unit_defines.svh"

module hdlc_back
  import hdlc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire hdlc_item_t q_item,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  hdlc_bk_state_t state_r, state_nxt;
  logic           esc_r, esc_nxt;
  logic           has_r, has_nxt;
  hdlc_item_t     cur_r;

  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r;
  logic           out_end_r;

  logic           emit;
  logic [7:0]     sel_byte;
  logic           needs_esc;
  logic           step_done;
  logic           item_done;
  logic [7:0]     line_byte;
  logic           line_end;

  assign emit = has_r && (!out_valid_r || out_tready);

  // Output decode: pick the byte of the current phase and escape it.
  always_comb begin
    case (state_r)
      BK_DATA:   sel_byte = cur_r.data;
      BK_FCS_LO: sel_byte = cur_r.fcs[7:0];
      BK_FCS_HI: sel_byte = cur_r.fcs[15:8];
      BK_FLAG:   sel_byte = FLAG_BYTE;
      default:   sel_byte = FLAG_BYTE;
    endcase
    needs_esc = (state_r != BK_FLAG) && ((sel_byte == FLAG_BYTE) || (sel_byte == ESC_BYTE));
    if (esc_r) begin
      line_byte = sel_byte ^ ESC_XOR;
    end else if (needs_esc) begin
      line_byte = ESC_BYTE;
    end else begin
      line_byte = sel_byte;
    end
    line_end  = (state_r == BK_FLAG);
    step_done = !needs_esc || esc_r;
    item_done = emit && step_done &&
                ((state_r == BK_FLAG) || ((state_r == BK_DATA) && !cur_r.last));
    q_pop     = !q_empty && (!has_r || item_done);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (emit && step_done) begin
      case (state_r)
        BK_DATA:   state_nxt = cur_r.last ? BK_FCS_LO : BK_DATA;
        BK_FCS_LO: state_nxt = BK_FCS_HI;
        BK_FCS_HI: state_nxt = BK_FLAG;
        BK_FLAG:   state_nxt = BK_DATA;
        default:   state_nxt = BK_DATA;
      endcase
    end
    esc_nxt       = emit ? (needs_esc && !esc_r) : esc_r;
    has_nxt       = q_pop ? 1'b1 : (item_done ? 1'b0 : has_r);
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_DATA;
      esc_r       <= 1'b0;
      has_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      has_r       <= has_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (emit) begin
      out_byte_r <= line_byte;
      out_end_r  <= line_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_end_r;

  `HDLC_ASSERT_NOW(a_end_is_flag, clk, rst_n, out_valid_r && out_end_r, out_byte_r == FLAG_BYTE, "frame end without flag byte")
  `HDLC_ASSERT_NOW(a_no_esc_on_flag, clk, rst_n, esc_r, state_r != BK_FLAG, "escape pending on closing flag")
  `HDLC_ASSERT_NOW(a_tail_has_last, clk, rst_n, state_r != BK_DATA, has_r && cur_r.last, "tail phase without last byte")
  `HDLC_ASSERT_NEXT(a_esc_follows, clk, rst_n, emit && needs_esc && !esc_r, esc_r && out_valid_r && (out_byte_r == ESC_BYTE), "escape byte not followed up")

endmodule

`default_nettype wire

>>> rtl/async_hdlc_framer_crc16_unit.sv
//  channel | dir | tdata [lsb..]     | tlast      | tuser
//  in_     | in  | data_byte[7:0]    | frame_last | -
//  out_    | out | line_byte[7:0]    | frame_end  | -
//
//  Front end folds each byte into CRC-16/X-25 in the accept cycle and queues it
//  with its FCS; one input transfer per cycle while the queue has room.
//  Back end sends line bytes: a plain byte goes out as one, an escaped byte as
//  two, and a last byte adds three to five (FCS low, FCS high, flag); output
//  register limits throughput to one line byte per cycle while the receiver is ready.
//  Reset (rst_n low, synchronous) empties queue and output, CRC to 0xFFFF.
//  Either side may stall; the FIFO_DEPTH-entry queue decouples them.
`timescale 1ns / 1ps
`default_nettype none

module async_hdlc_framer_crc16_unit
  import hdlc_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // frame_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] line_byte
  output logic            out_tlast   // frame_end
);

  hdlc_item_t push_item;
  hdlc_item_t head_item;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  // Front: accept, CRC, classify into queue entries.
  hdlc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Short queue between front and back.
  hdlc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (head_item)
  );

  // Back: escape, FCS append, closing flag, output register.
  hdlc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> test/async_hdlc_framer_crc16_unit_test.sv
`timescale 1ns / 1ps

module async_hdlc_framer_crc16_unit_test
  import hdlc_pkg::*;
();

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 140;
  localparam int SETTLE       = 40;      // quiet cycles after the last line byte

  typedef struct {
    logic [7:0] data;
    logic       last;
  } payload_t;

  typedef struct {
    logic [7:0] octet;
    logic       frame_end;
  } line_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic       in_tlast = 1'b0;    // frame_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] line_byte
  logic       out_tlast;          // frame_end

  // Payload bytes still to be offered, and line bytes the framer owes us.
  payload_t payload_q[$];
  line_t    line_due[$];

  // Predictor state: running CRC-16/X-25 of the frame in progress.
  logic [15:0] model_crc = CRC_INIT;

  // Stall rates in percent, changed per phase by the stimulus block.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int errors        = 0;
  int items_sent    = 0;
  int frames_sent   = 0;
  int lines_checked = 0;
  int escapes_seen  = 0;
  int cycle_count   = 0;

  async_hdlc_framer_crc16_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bitwise reflected CRC: feed data LSB first, poly applied on feedback bit.
  function automatic logic [15:0] x25_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // Byte stuffing: flag and escape go out as ESC, byte ^ 0x20.
  task automatic stuff_byte(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      line_due.push_back('{ESC_BYTE, 1'b0});
      line_due.push_back('{b ^ ESC_XOR, 1'b0});
    end else begin
      line_due.push_back('{b, 1'b0});
    end
  endtask

  // Expected line bytes for one accepted payload byte.
  task automatic frame_payload_byte(input logic [7:0] data, input logic last);
    logic [15:0] fcs;
    model_crc = x25_fold(model_crc, data);
    stuff_byte(data);
    if (last) begin
      // FCS is the complement, low byte first, then the closing flag
      fcs = ~model_crc;
      stuff_byte(fcs[7:0]);
      stuff_byte(fcs[15:8]);
      line_due.push_back('{FLAG_BYTE, 1'b1});
      model_crc = CRC_INIT;
      frames_sent++;
    end
  endtask

  task automatic add_payload(input logic [7:0] data, input logic last);
    payload_q.push_back('{data, last});
  endtask

  // Two-byte frame whose FCS byte (low or high) equals target, so the
  // escape path is exercised inside the FCS itself.
  task automatic add_fcs_escape_frame(input bit high_half, input logic [7:0] target);
    logic [15:0] fcs;
    bit          found;
    found = 1'b0;
    for (int p = 0; p < 256 && !found; p++) begin
      for (int l = 0; l < 256 && !found; l++) begin
        fcs = ~x25_fold(x25_fold(CRC_INIT, p[7:0]), l[7:0]);
        if ((high_half ? fcs[15:8] : fcs[7:0]) == target) begin
          add_payload(p[7:0], 1'b0);
          add_payload(l[7:0], 1'b1);
          found = 1'b1;
        end
      end
    end
  endtask

  // Random frames of mostly short length, biased toward the stuffed values and their escaped forms.
  task automatic add_random_frames(input int count);
    int added;
    int len;
    logic [7:0] b;
    added = 0;
    while (added < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 20) begin
          case ($urandom_range(3))
            0: b = FLAG_BYTE;
            1: b = ESC_BYTE;
            2: b = FLAG_BYTE ^ ESC_XOR;
            default: b = ESC_BYTE ^ ESC_XOR;
          endcase
        end else begin
          b = 8'($urandom_range(255));
        end
        add_payload(b, k == len - 1);
      end
      added += len;
    end
  endtask

  // Blocks until every payload byte is in and every line byte is out.
  task automatic wait_drained();
    while (payload_q.size() != 0 || line_due.size() != 0) @(posedge clk);
  endtask

  // Source side: hold a presented transfer until taken, then maybe idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        frame_payload_byte(in_tdata, in_tlast);
        void'(payload_q.pop_front());
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (payload_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= payload_q[0].data;
          in_tlast  <= payload_q[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each line transfer against the oldest expectation.
  always @(posedge clk) begin
    line_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (line_due.size() == 0) begin
          $display("%0t: unexpected line byte %02h end=%0b", $time, out_tdata, out_tlast);
          errors++;
        end else begin
          want = line_due.pop_front();
          if (out_tdata !== want.octet) begin
            $display("%0t: line_byte expected %02h actual %02h", $time, want.octet, out_tdata);
            errors++;
          end
          if (out_tlast !== want.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end,
                     out_tlast);
            errors++;
          end
          if (out_tdata == ESC_BYTE) escapes_seen++;
          lines_checked++;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d line bytes outstanding", cycle_count,
               line_due.size());
      $display("async_hdlc_framer_crc16_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender idles a quarter of the time, receiver about half.
    send_idle_pct = 25;
    recv_idle_pct = 49;

    // Directed: field extremes and both stuffed values, plus neighbors that
    // must not be stuffed, inside one multi-byte frame.
    add_payload(8'h00, 1'b0);
    add_payload(8'hFF, 1'b0);
    add_payload(FLAG_BYTE, 1'b0);
    add_payload(ESC_BYTE, 1'b0);
    add_payload(FLAG_BYTE ^ ESC_XOR, 1'b0);
    add_payload(ESC_BYTE ^ ESC_XOR, 1'b0);
    add_payload(ESC_XOR, 1'b1);
    // single-byte frames, including stuffed last bytes
    add_payload(FLAG_BYTE, 1'b1);
    add_payload(ESC_BYTE, 1'b1);
    add_payload(8'hFF, 1'b1);
    add_payload(8'h00, 1'b1);
    // FCS bytes that themselves need stuffing, in both halves
    add_fcs_escape_frame(1'b0, FLAG_BYTE);
    add_fcs_escape_frame(1'b0, ESC_BYTE);
    add_fcs_escape_frame(1'b1, FLAG_BYTE);
    add_fcs_escape_frame(1'b1, ESC_BYTE);
    wait_drained();

    add_random_frames(RANDOM_ITEMS / 3);
    wait_drained();

    // Phase 2: stall rates swapped.
    send_idle_pct = 49;
    recv_idle_pct = 25;
    add_random_frames(RANDOM_ITEMS / 3);
    wait_drained();

    // Phase 3: both sides always ready.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_frames(RANDOM_ITEMS / 3);
    wait_drained();

    // anything the framer still emits now shows up as unexpected
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d payload bytes in %0d frames, 3 stall profiles", items_sent,
             frames_sent);
    $display("checked %0d line bytes, %0d of them escapes", lines_checked, escapes_seen);
    if (errors == 0) begin
      $display("async_hdlc_framer_crc16_unit: match");
    end else begin
      $display("async_hdlc_framer_crc16_unit: mismatch");
    end
    $finish;
  end

endmodule
